// ===== design/kth_order_magnitude_shrink_core_defines.svh =====
// Assertion macros for the blocks that check themselves.
`ifndef KTH_ORDER_MAGNITUDE_SHRINK_CORE_DEFINES_SVH
`define KTH_ORDER_MAGNITUDE_SHRINK_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KOMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define KOMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/kmsh_pkg.sv =====
package kmsh_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int MAG_W       = 15;
	localparam int RANK_W      = 7;
	localparam int MAX_LEN_DEF = 64;
	localparam logic [RANK_W-1:0] RANK_RESET = 7'd40;

	typedef logic [MAG_W-1:0] mag_t;

	// Per-cycle commands broadcast to every cell of the chain
	typedef struct packed {
		logic ins;  // insert new magnitude into the sorted chain
		logic shd;  // shift sorted chain toward cell 0
		logic clr;  // drop all sorted entries
		logic osh;  // advance the load-order chain by one cell
	} cell_ctrl_t;

	// Magnitude of a Q8.8 sample; the most negative code saturates
	function automatic mag_t mag_of(input logic [SAMPLE_W-1:0] s);
		logic [SAMPLE_W-1:0] neg;
		begin
			neg = ~s + 1'b1;
			if (!s[SAMPLE_W-1]) begin
				mag_of = s[MAG_W-1:0];
			end else if (neg[SAMPLE_W-1]) begin
				mag_of = '1;
			end else begin
				mag_of = neg[MAG_W-1:0];
			end
		end
	endfunction

endpackage

// ===== design/kth_order_magnitude_shrink_core.sv =====
// Soft thresholding of Q7.8 magnitudes of Q8.8 samples. Samples load at one per
// cycle into a chain of MAX_LEN cells that keeps them both in ascending order
// and in load order; samples past MAX_LEN are dropped, and the transaction
// flagged last closes the vector. After the last sample the chain shifts to
// bring the min(n,k)-th smallest magnitude to cell 0 and the oldest sample to
// the top cell (n = stored length, k = rank_k, 0 read as 1), then emits n
// results, one per cycle while out_ready is high. New samples are taken only
// during the load phase; the final result may still sit in the output
// register while the next vector loads. rank_k is written through the cfg
// channel, which is always ready; the user must write it only while the block
// is idle, which the block itself does not enforce.
module kth_order_magnitude_shrink_core import kmsh_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                last,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [MAG_W-1:0]    shrunk,
	output logic                above,
	output logic                final_res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [RANK_W-1:0]   cfg_data
);

`include "kth_order_magnitude_shrink_core_defines.svh"

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int WW = (CW > RANK_W) ? CW : RANK_W;

	typedef enum logic [1:0] {ST_LOAD, ST_ALIGN, ST_EMIT} state_t;

	state_t            state_q;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     sort_cnt_q;
	logic [CW-1:0]     ord_cnt_q;
	logic [RANK_W-1:0] rank_q;
	logic              out_valid_q;
	mag_t              shrunk_q;
	logic              above_q;
	logic              final_q;

	cell_ctrl_t         ctrl;
	mag_t               new_mag;
	mag_t               sval [MAX_LEN];
	logic [MAX_LEN-1:0] svld;
	logic [MAX_LEN-1:0] keep;
	mag_t               ord  [MAX_LEN];

	logic          in_acc;
	logic          full;
	logic          emit_take;
	logic [CW-1:0] n_next;
	logic [RANK_W-1:0] rank_eff;
	logic [WW-1:0] k_w;
	logic [WW-1:0] n_w;
	logic [WW-1:0] pick_w;
	mag_t          thr;
	mag_t          head;
	logic          up;

	assign in_ready  = (state_q == ST_LOAD);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign full      = (fill_q == CW'(MAX_LEN));
	assign new_mag   = mag_of(sample);

	// Threshold rank for the closing transaction: min(n, k) - 1
	assign n_next   = fill_q + CW'(!full);
	assign rank_eff = (rank_q == '0) ? RANK_W'(1) : rank_q;
	assign k_w      = WW'(rank_eff);
	assign n_w      = WW'(n_next);
	assign pick_w   = (k_w >= n_w) ? (n_w - WW'(1)) : (k_w - WW'(1));

	// Result of the oldest remaining sample against the threshold
	assign thr  = sval[0];
	assign head = ord[MAX_LEN-1];
	assign up   = head > thr;

	assign emit_take = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// Chain commands
	always_comb begin
		ctrl.ins = in_acc && !full;
		ctrl.shd = (state_q == ST_ALIGN) && (sort_cnt_q != '0);
		ctrl.clr = emit_take && (fill_q == CW'(1));
		ctrl.osh = ctrl.ins || ((state_q == ST_ALIGN) && (ord_cnt_q != '0)) || emit_take;
	end

	// Cell chain
	for (genvar gi = 0; gi < MAX_LEN; gi++) begin : g_cell
		logic lo_k;
		logic lo_vd;
		mag_t lo_v;
		logic hi_vd;
		mag_t hi_v;
		mag_t o_in;

		if (gi == 0) begin : g_first
			assign lo_k  = 1'b1;
			assign lo_vd = 1'b0;
			assign lo_v  = '0;
			assign o_in  = new_mag;
		end else begin : g_mid
			assign lo_k  = keep[gi-1];
			assign lo_vd = svld[gi-1];
			assign lo_v  = sval[gi-1];
			assign o_in  = ord[gi-1];
		end

		if (gi == MAX_LEN - 1) begin : g_top
			assign hi_vd = 1'b0;
			assign hi_v  = '0;
		end else begin : g_below
			assign hi_vd = svld[gi+1];
			assign hi_v  = sval[gi+1];
		end

		kmsh_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.ins_val (new_mag),
			.lo_keep (lo_k),
			.lo_val  (lo_v),
			.lo_vld  (lo_vd),
			.hi_val  (hi_v),
			.hi_vld  (hi_vd),
			.ord_in  (o_in),
			.sval    (sval[gi]),
			.svld    (svld[gi]),
			.keep    (keep[gi]),
			.ord     (ord[gi])
		);
	end

	// Rank register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= RANK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rank_q <= cfg_data;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			fill_q      <= '0;
			sort_cnt_q  <= '0;
			ord_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			shrunk_q    <= '0;
			above_q     <= 1'b0;
			final_q     <= 1'b0;
		end else begin
			// Load a new result, else drop the one taken downstream
			if (emit_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						fill_q <= n_next;
						if (last) begin
							sort_cnt_q <= CW'(pick_w);
							ord_cnt_q  <= CW'(MAX_LEN) - n_next;
							state_q    <= ST_ALIGN;
						end
					end
				end
				ST_ALIGN: begin
					if (sort_cnt_q != '0) begin
						sort_cnt_q <= sort_cnt_q - CW'(1);
					end
					if (ord_cnt_q != '0) begin
						ord_cnt_q <= ord_cnt_q - CW'(1);
					end
					if (sort_cnt_q == '0 && ord_cnt_q == '0) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_take) begin
						shrunk_q    <= up ? (head - thr) : '0;
						above_q     <= up;
						final_q     <= (fill_q == CW'(1));
						fill_q      <= fill_q - CW'(1);
						if (fill_q == CW'(1)) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign shrunk    = shrunk_q;
	assign above     = above_q;
	assign final_res = final_q;

	// Checks
	`KOMS_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CW'(MAX_LEN), "fill count beyond depth")
	`KOMS_ASSERT_NOW(a_sorted_count, state_q == ST_LOAD, $countones(svld) == int'(fill_q), "sorted chain out of step with fill count")
	`KOMS_ASSERT_NOW(a_thr_valid, state_q == ST_EMIT, svld[0], "threshold cell empty while emitting")
	`KOMS_ASSERT_NOW(a_above_shrunk, out_valid_q, above_q == (shrunk_q != '0), "above flag disagrees with shrunk value")
	`KOMS_ASSERT_NEXT(a_final_idle, emit_take && fill_q == CW'(1), state_q == ST_LOAD && fill_q == '0 && final_q, "vector not closed after final result")

endmodule

// ===== design/kmsh_cell.sv =====
module kmsh_cell import kmsh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  mag_t       ins_val,
	input  logic       lo_keep,
	input  mag_t       lo_val,
	input  logic       lo_vld,
	input  mag_t       hi_val,
	input  logic       hi_vld,
	input  mag_t       ord_in,
	output mag_t       sval,
	output logic       svld,
	output logic       keep,
	output mag_t       ord
);

	mag_t sval_q;
	logic svld_q;
	mag_t ord_q;

	// Hold own entry when it is valid and not above the new value
	assign keep = svld_q && (sval_q <= ins_val);

	assign sval = sval_q;
	assign svld = svld_q;
	assign ord  = ord_q;

	// Valid bit of the sorted entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			svld_q <= 1'b0;
		end else if (ctrl.clr) begin
			svld_q <= 1'b0;
		end else if (ctrl.ins) begin
			if (!keep) begin
				svld_q <= lo_keep ? 1'b1 : lo_vld;
			end
		end else if (ctrl.shd) begin
			svld_q <= hi_vld;
		end
	end

	// Sorted value: take the new value at the insertion point, else push up
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!keep) begin
				sval_q <= lo_keep ? ins_val : lo_val;
			end
		end else if (ctrl.shd) begin
			sval_q <= hi_val;
		end
	end

	// Load-order shift line
	always_ff @(posedge clk) begin
		if (ctrl.osh) begin
			ord_q <= ord_in;
		end
	end

endmodule
